// ----- rtl/alwn_pkg.sv -----
// Package for the assembly line whitespace normaliser.
// Holds byte codes, the result record and the core-to-queue push record.
// No dependencies.
package alwn_pkg;

  localparam logic [7:0] BYTE_COMMA   = 8'h2C;
  localparam logic [7:0] BYTE_QUOTE   = 8'h22;
  localparam logic [7:0] BYTE_LPAREN  = 8'h28;
  localparam logic [7:0] BYTE_RPAREN  = 8'h29;
  localparam logic [7:0] BYTE_BSLASH  = 8'h5C;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] COMMENT_RST  = 8'h23;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       line_end;
    logic       line_dropped;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ----- rtl/assembly_line_whitespace_normalizer.sv -----
// Normalises one assembly source line, one byte per input transfer: outside
// strings, blanks and commas fold to a single space that is sent only when a
// later byte needs it; a comment byte (register, reset '#') drops the rest of
// the line; quotes get a separating space. A byte gives zero, one or two
// results, and the final byte of a line always gives at least one, carrying
// tlast. Input is taken every cycle while the four-entry result queue holds
// two results or fewer, so plain bytes stream at one per cycle. A byte that
// yields two results needs an output transfer for each; with the output always
// ready the queue absorbs one such surplus, and each further one stalls the
// input until an entry drains, unless bytes that yield nothing (folded blanks,
// comment bytes) have made up the time. With the queue empty, a transfer's
// first result is offered in the cycle after it.
// Depends on alwn_pkg, alwn_core and alwn_outq.
module assembly_line_whitespace_normalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // comment_char
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] ch
  input  logic       in_tlast,      // line_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_char
  output logic [1:0] out_tuser,     // [0] char_valid, [1] line_dropped
  output logic       out_tlast      // line_end
);

  alwn_pkg::push_t push;
  alwn_pkg::res_t  res;
  logic            acc;

  assign acc = in_tvalid && in_tready;

  alwn_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .ch          (in_tdata),
    .line_last   (in_tlast),
    .push        (push)
  );

  alwn_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (acc),
    .push      (push),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = res.out_char;
  assign out_tuser = {res.line_dropped, res.char_valid};
  assign out_tlast = res.line_end;

endmodule

// ----- rtl/alwn_core.sv -----
// Normaliser core: line state flags, comment byte register and the
// per-byte decision logic. Produces up to two results per transfer.
// Depends on alwn_pkg.
module alwn_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 acc,
  input  logic [7:0]           ch,
  input  logic                 line_last,
  output alwn_pkg::push_t      push
);

  logic [7:0] comment_r;
  logic after_space_r, space_pending_r, inside_string_r;
  logic last_bs_r, in_comment_r, emitted_r;
  logic after_space_nxt, space_pending_nxt, inside_string_nxt;
  logic last_bs_nxt, in_comment_nxt, emitted_nxt;
  logic emit_sp, emit_c, blank, esc_q, next_bs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comment_r       <= alwn_pkg::COMMENT_RST;
      after_space_r   <= 1'b1;
      space_pending_r <= 1'b0;
      inside_string_r <= 1'b0;
      last_bs_r       <= 1'b0;
      in_comment_r    <= 1'b0;
      emitted_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        comment_r <= cfg_wr_data;
      end
      if (acc) begin
        after_space_r   <= after_space_nxt;
        space_pending_r <= space_pending_nxt;
        inside_string_r <= inside_string_nxt;
        last_bs_r       <= last_bs_nxt;
        in_comment_r    <= in_comment_nxt;
        emitted_r       <= emitted_nxt;
      end
    end
  end

  always_comb begin
    blank   = (ch inside {alwn_pkg::BYTE_COMMA, alwn_pkg::BYTE_SPACE,
                          [alwn_pkg::BYTE_TAB:alwn_pkg::BYTE_CR]});
    esc_q   = (ch == alwn_pkg::BYTE_QUOTE) && last_bs_r;
    next_bs = (ch == alwn_pkg::BYTE_BSLASH) && !last_bs_r;

    emit_sp           = 1'b0;
    emit_c            = 1'b0;
    after_space_nxt   = after_space_r;
    space_pending_nxt = space_pending_r;
    inside_string_nxt = inside_string_r;
    last_bs_nxt       = last_bs_r;
    in_comment_nxt    = in_comment_r;

    if (!in_comment_r) begin
      if (inside_string_r) begin
        emit_c = 1'b1;
        if (ch == alwn_pkg::BYTE_QUOTE && !esc_q) begin
          inside_string_nxt = 1'b0;
          space_pending_nxt = 1'b1;
          after_space_nxt   = 1'b1;
        end else begin
          after_space_nxt = 1'b0;
        end
        last_bs_nxt = next_bs;
      end else if (blank) begin
        if (!after_space_r) begin
          space_pending_nxt = 1'b1;
          after_space_nxt   = 1'b1;
        end
        last_bs_nxt = 1'b0;
      end else if (ch == comment_r) begin
        in_comment_nxt    = 1'b1;
        space_pending_nxt = 1'b0;
      end else if (ch == alwn_pkg::BYTE_QUOTE && !esc_q) begin
        emit_sp           = space_pending_r || !after_space_r;
        emit_c            = 1'b1;
        space_pending_nxt = 1'b0;
        after_space_nxt   = 1'b0;
        inside_string_nxt = 1'b1;
        last_bs_nxt       = 1'b0;
      end else if (ch == alwn_pkg::BYTE_LPAREN || ch == alwn_pkg::BYTE_RPAREN) begin
        space_pending_nxt = 1'b0;
        emit_c            = 1'b1;
        after_space_nxt   = 1'b1;
        last_bs_nxt       = 1'b0;
      end else begin
        emit_sp           = space_pending_r;
        space_pending_nxt = 1'b0;
        emit_c            = 1'b1;
        after_space_nxt   = 1'b0;
        last_bs_nxt       = next_bs;
      end
    end

    emitted_nxt = emitted_r || emit_c;

    // first and second result slots
    push.r0.out_char     = emit_sp ? alwn_pkg::BYTE_SPACE : ch;
    push.r0.char_valid   = 1'b1;
    push.r0.line_end     = 1'b0;
    push.r0.line_dropped = 1'b0;
    push.r1.out_char     = ch;
    push.r1.char_valid   = 1'b1;
    push.r1.line_end     = line_last;
    push.r1.line_dropped = 1'b0;
    push.n               = {1'b0, emit_sp} + {1'b0, emit_c};

    if (line_last) begin
      if (!emit_c) begin
        // nothing emitted on the final byte: bare line-end marker
        push.n               = 2'd1;
        push.r0.out_char     = 8'h00;
        push.r0.char_valid   = 1'b0;
        push.r0.line_end     = 1'b1;
        push.r0.line_dropped = !emitted_r;
      end else if (!emit_sp) begin
        push.r0.line_end = 1'b1;
      end
      after_space_nxt   = 1'b1;
      space_pending_nxt = 1'b0;
      inside_string_nxt = 1'b0;
      last_bs_nxt       = 1'b0;
      in_comment_nxt    = 1'b0;
      emitted_nxt       = 1'b0;
    end
  end

endmodule

// ----- rtl/alwn_outq.sv -----
// Result queue: four-entry register queue taking up to two results per
// cycle and releasing one per output transfer. Depends on alwn_pkg.
module alwn_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_en,
  input  alwn_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output alwn_pkg::res_t    out_res
);

  alwn_pkg::res_t mem_r [alwn_pkg::QDEPTH];
  logic [alwn_pkg::QAW-1:0] wp_r, rp_r, wp_nxt, rp_nxt, wp1;
  logic [alwn_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic [1:0]               nin;
  logic                     pop;

  assign nin       = push_en ? push.n : 2'd0;
  assign pop       = out_valid && out_ready;
  assign wp1       = wp_r + 1'b1;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rp_r];
  assign room      = (cnt_r <= (alwn_pkg::QAW+1)'(alwn_pkg::QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + alwn_pkg::QAW'(nin);
    rp_nxt  = rp_r + alwn_pkg::QAW'(pop);
    cnt_nxt = cnt_r + (alwn_pkg::QAW+1)'(nin) - (alwn_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (nin != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (nin == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

endmodule

// ----- rtl/alwn_checker.sv -----
// Port-level checker for the whitespace normaliser, bound to the top level.
// Depends on nothing but the top level's ports.
module alwn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not empty after reset");

  a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending results");

  a_dropped_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("dropped flag off a bare line end");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata == 8'h00)
    else $error("byteless result not a line end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind assembly_line_whitespace_normalizer alwn_checker u_alwn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/assembly_line_whitespace_normalizer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for assembly_line_whitespace_normalizer.
// Streams directed and random source lines against an in-bench predictor of the
// folding rules; needs alwn_pkg and the normaliser RTL only.
module assembly_line_whitespace_normalizer_test;
  import alwn_pkg::*;

  class line_norm_scoreboard;
    res_t       pending[$];
    logic [7:0] comment_byte;
    bit after_blank, blank_held, in_quotes, held_bslash, skipping, line_has_output;
    int errors, results_seen, lines, dropped_lines;

    function new();
      comment_byte = COMMENT_RST;
      clear_line();
    endfunction

    function void clear_line();
      after_blank     = 1'b1;
      blank_held      = 1'b0;
      in_quotes       = 1'b0;
      held_bslash     = 1'b0;
      skipping        = 1'b0;
      line_has_output = 1'b0;
    endfunction

    function void put(logic [7:0] b);
      res_t r;
      r.out_char     = b;
      r.char_valid   = 1'b1;
      r.line_end     = 1'b0;
      r.line_dropped = 1'b0;
      pending.push_back(r);
      line_has_output = 1'b1;
    endfunction

    // work out the results caused by one accepted input transfer
    function void note_input(logic [7:0] c, logic last);
      int   depth_in;
      bit   esc_quote, next_bslash;
      res_t r;
      depth_in = pending.size();
      if (!skipping) begin
        esc_quote   = (c == BYTE_QUOTE) && held_bslash;
        next_bslash = (c == BYTE_BSLASH) && !held_bslash;
        if (in_quotes) begin
          put(c);
          if (c == BYTE_QUOTE && !esc_quote) begin
            in_quotes   = 1'b0;
            blank_held  = 1'b1;
            after_blank = 1'b1;
          end else begin
            after_blank = 1'b0;
          end
          held_bslash = next_bslash;
        end else if (c == BYTE_COMMA || c == BYTE_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
          if (!after_blank) begin
            blank_held  = 1'b1;
            after_blank = 1'b1;
          end
          held_bslash = 1'b0;
        end else if (c == comment_byte) begin
          skipping   = 1'b1;
          blank_held = 1'b0;
        end else if (c == BYTE_QUOTE && !esc_quote) begin
          if (blank_held || !after_blank) put(BYTE_SPACE);
          put(c);
          blank_held  = 1'b0;
          after_blank = 1'b0;
          in_quotes   = 1'b1;
          held_bslash = 1'b0;
        end else if (c == BYTE_LPAREN || c == BYTE_RPAREN) begin
          blank_held = 1'b0;
          put(c);
          after_blank = 1'b1;
          held_bslash = 1'b0;
        end else begin
          if (blank_held) put(BYTE_SPACE);
          blank_held = 1'b0;
          put(c);
          after_blank = 1'b0;
          held_bslash = next_bslash;
        end
      end
      if (last) begin
        if (pending.size() == depth_in) begin
          r = '0;
          pending.push_back(r);
        end
        pending[pending.size() - 1].line_end     = 1'b1;
        pending[pending.size() - 1].line_dropped = !line_has_output;
        lines++;
        if (!line_has_output) dropped_lines++;
        clear_line();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [7:0] data, logic [1:0] user, logic eol);
      res_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result %0d unexpected: byte %02h user %b last %b",
                         results_seen, data, user, eol));
        return;
      end
      want = pending.pop_front();
      if (data !== want.out_char || user[0] !== want.char_valid ||
          user[1] !== want.line_dropped || eol !== want.line_end)
        report($sformatf({"result %0d: byte %02h valid %b dropped %b end %b, ",
                          "wanted %02h %b %b %b"}, results_seen, data, user[0], user[1],
                         eol, want.out_char, want.char_valid, want.line_dropped,
                         want.line_end));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  line_norm_scoreboard sb = new();
  logic [7:0] line_buf[$];
  logic [7:0] cur_comment = COMMENT_RST;
  logic [7:0] comment_set[8];
  int         burst_left = 0;
  int         items_sent = 0;
  bit         rx_hold_req = 1'b0;

  assembly_line_whitespace_normalizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // receiver: rotating 16-bit stall pattern, redrawn at the start of each span, plus one long hold-off
  initial begin
    int          hold_left;
    int          span;
    logic [15:0] pat;
    hold_left = 0;
    span      = 0;
    pat       = 16'hFFFF;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = 400;
      end
      if (span == 0) begin
        span = 64;
        pat  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= pat[0];
      end
      pat = {pat[0], pat[15:1]};
    end
  end

  initial begin
    #4_000_000;
    $display("assembly_line_whitespace_normalizer_test: FAIL");
    $finish;
  end

  function automatic logic [7:0] blank_byte();
    int k;
    k = $urandom_range(0, 6);
    if (k == 6) return BYTE_COMMA;
    if (k == 5) return BYTE_SPACE;
    return 8'(9 + k);
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: return BYTE_QUOTE;
      1: return BYTE_BSLASH;
      2: return BYTE_LPAREN;
      3: return BYTE_RPAREN;
      4: return BYTE_COMMA;
      5: return BYTE_SPACE;
      6: return BYTE_TAB;
      7: return cur_comment;
      8: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic put_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_buf.push_back(blank_byte());
  endtask

  task automatic put_word(int len);
    string chars;
    chars = "abcdefghijklmnopqrstuvwxyz0123456789$._";
    repeat (len) line_buf.push_back(chars[$urandom_range(0, chars.len() - 1)]);
  endtask

  task automatic put_string(bit close);
    line_buf.push_back(BYTE_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 5))
        0: begin
          line_buf.push_back(BYTE_BSLASH);
          line_buf.push_back(BYTE_QUOTE);
        end
        1: line_buf.push_back(blank_byte());
        2: line_buf.push_back(cur_comment);
        3: line_buf.push_back(BYTE_BSLASH);
        4: line_buf.push_back(noise_byte());
        default: line_buf.push_back(8'($urandom_range(32, 126)));
      endcase
    end
    if (close) line_buf.push_back(BYTE_QUOTE);
  endtask

  // mostly plausible statements, some raw noise, some blank or unterminated lines
  task automatic build_line();
    int kind;
    int nops;
    line_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      put_blanks(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        put_word($urandom_range(1, 5));
        line_buf.push_back(8'h3A);
        put_blanks(1, 2);
      end
      put_word($urandom_range(1, 4));
      nops = $urandom_range(0, 3);
      for (int i = 0; i < nops; i++) begin
        if (i == 0) begin
          put_blanks(1, 2);
        end else begin
          line_buf.push_back(BYTE_COMMA);
          put_blanks(0, 1);
        end
        case ($urandom_range(0, 2))
          0: put_word($urandom_range(1, 5));
          1: begin
            put_word($urandom_range(1, 3));
            line_buf.push_back(BYTE_LPAREN);
            put_blanks(0, 1);
            put_word($urandom_range(2, 3));
            put_blanks(0, 1);
            line_buf.push_back(BYTE_RPAREN);
          end
          default: put_string($urandom_range(0, 7) != 0);
        endcase
      end
      put_blanks(0, 2);
      if ($urandom_range(0, 2) == 0) begin
        line_buf.push_back(cur_comment);
        repeat ($urandom_range(0, 5)) line_buf.push_back(noise_byte());
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(noise_byte());
    end else begin
      put_blanks(1, 3);
      if ($urandom_range(0, 1) == 0) begin
        put_string(1'b0);
        put_blanks(0, 3);
      end
    end
  endtask

  task automatic send_item(logic [7:0] c, logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = 64;
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(c, last);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_item(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  // only once the block has drained: no transfers in flight
  task automatic cfg_write(logic [7:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    sb.comment_byte = v;
    cur_comment     = v;
    burst_left      = 0;
  endtask

  initial begin
    int quota;
    int count;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'h00;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    comment_set = '{COMMENT_RST, 8'h00, 8'hFF, BYTE_SPACE, BYTE_QUOTE, BYTE_COMMA,
                    8'h3B, 8'($urandom_range(0, 255))};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blanks, parens, byte extremes; line closes on a blank
    line_buf = '{BYTE_TAB, 8'h78, BYTE_COMMA, BYTE_LPAREN, 8'hFF, BYTE_SPACE, BYTE_RPAREN,
                 8'h00, BYTE_SPACE};
    send_line();
    // comment byte and escaped quote in a string, then comment, bytes after it
    send_text("\"#\\\" \"b#z");
    // double backslash, unterminated string ending in a tab
    send_text("\\\\\"\t");
    // escaped quote outside a string
    send_text("\\\"#q");
    // lines that emit nothing
    send_text(",");
    send_text("#");

    for (int p = 0; p < 8; p++) begin
      cfg_write(comment_set[p]);
      if (p == 1) rx_hold_req = 1'b1;
      quota = (p == 1) ? 140 : 70;
      count = 0;
      while (count < quota) begin
        build_line();
        send_line();
        count += line_buf.size();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input transfers over %0d lines (%0d dropped), %0d results checked",
             items_sent, sb.lines, sb.dropped_lines, sb.results_seen);
    $display("comment bytes used: %02h %02h %02h %02h %02h %02h %02h %02h", comment_set[0],
             comment_set[1], comment_set[2], comment_set[3], comment_set[4], comment_set[5],
             comment_set[6], comment_set[7]);
    if (sb.errors == 0) begin
      $display("assembly_line_whitespace_normalizer_test: PASS");
    end else begin
      $display("assembly_line_whitespace_normalizer_test: FAIL");
    end
    $finish;
  end

endmodule
